/* hw/rtl/top_k_dot_product_search_top_assert.svh */
// ---------------------------------------------------------------------------
// top_k_dot_product_search_top_assert.svh
// Assertion macros used by the checker file of the search block.
// ---------------------------------------------------------------------------
`ifndef TOP_K_DOT_PRODUCT_SEARCH_TOP_ASSERT_SVH
`define TOP_K_DOT_PRODUCT_SEARCH_TOP_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while in reset
`define TKDP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("tkdp check failed: same-cycle rule");

// Next-cycle implication, sampled on i_clk, off while in reset
`define TKDP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("tkdp check failed: next-cycle rule");

`endif

/* hw/rtl/tkdp_pkg.sv */
// ---------------------------------------------------------------------------
// tkdp_pkg
// Sizes, codes and shared types of the top-k dot product search block.
// ---------------------------------------------------------------------------
package tkdp_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int MAX_DIMS    = 64;
    localparam int MAX_TOP_K   = 16;

    // derived widths
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
    localparam int DIM_W       = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int DLEN_W      = $clog2(MAX_DIMS + 1);
    localparam int K_W         = $clog2(MAX_TOP_K + 1);
    localparam int SLOT_W      = (MAX_TOP_K > 1) ? $clog2(MAX_TOP_K) : 1;
    localparam int STORE_DEPTH = MAX_ENTRIES << DIM_W;
    localparam int STORE_AW    = IDX_W + DIM_W;
    localparam int ACC_W       = 32 + DLEN_W;
    localparam int FIFO_DEPTH  = 2;

    // fixed field widths
    localparam int ELEM_W      = 16;
    localparam int CFG_W       = 7;
    localparam int TOPK_IN_W   = 5;
    localparam int OUT_IDX_W   = 8;
    localparam int SIM_W       = 32;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_QUERY  = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_MATCH = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // job handed from front to back; ST_MATCH means run a scan
    typedef struct packed {
        t_status             kind;
        logic [K_W-1:0]      k;
        logic [COUNT_W-1:0]  count;
        logic [DLEN_W-1:0]   qlen;
        logic [DLEN_W-1:0]   dims;
    } t_job;

    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
        logic [ELEM_W-1:0]   data;
    } t_store_wr;

    typedef struct packed {
        logic                en;
        logic [IDX_W-1:0]    addr;
        logic [DLEN_W-1:0]   data;
    } t_len_wr;

    typedef struct packed {
        logic                en;
        logic [DIM_W-1:0]    addr;
        logic [ELEM_W-1:0]   data;
    } t_qry_wr;

    typedef struct packed {
        logic                valid;
        logic [IDX_W-1:0]    idx;
        logic [SIM_W-1:0]    sim;
    } t_best;

endpackage

/* hw/rtl/tkdp_ram.sv */
// ---------------------------------------------------------------------------
// tkdp_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module tkdp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/tkdp_front.sv */
// ---------------------------------------------------------------------------
// tkdp_front
// Takes items, loads store and query memories, and posts jobs to the back.
// ---------------------------------------------------------------------------
module tkdp_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_item_valid,
    input  logic [1:0]                        i_func,
    input  logic signed [tkdp_pkg::ELEM_W-1:0] i_element_value,
    input  logic                              i_last_element,
    input  logic [tkdp_pkg::TOPK_IN_W-1:0]    i_top_k,
    input  logic                              i_cfg_we,
    input  logic [tkdp_pkg::CFG_W-1:0]        i_cfg_dims,
    output tkdp_pkg::t_job                    o_job,
    output logic                              o_job_push,
    output tkdp_pkg::t_store_wr               o_store_wr,
    output tkdp_pkg::t_len_wr                 o_len_wr,
    output tkdp_pkg::t_qry_wr                 o_qry_wr
);
    import tkdp_pkg::*;

    logic [CFG_W-1:0]   r_dims_cfg;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [DIM_W-1:0]   r_sptr, n_sptr;
    logic [DIM_W-1:0]   r_qptr, n_qptr;

    logic [DLEN_W-1:0]  eff_dims;
    logic [K_W-1:0]     k_clamp;
    logic [K_W-1:0]     k_want;
    logic               full;
    logic               s_done;
    logic               q_done;
    logic [DLEN_W-1:0]  s_next;
    logic [DLEN_W-1:0]  q_next;

    // effective vector length, 1..MAX_DIMS
    always_comb begin
        if (r_dims_cfg == '0) begin
            eff_dims = DLEN_W'(1);
        end else if (int'(r_dims_cfg) > MAX_DIMS) begin
            eff_dims = DLEN_W'(MAX_DIMS);
        end else begin
            eff_dims = DLEN_W'(r_dims_cfg);
        end
    end

    // top_k clamped to 1..MAX_TOP_K, then to the entry count
    always_comb begin
        if (i_top_k == '0) begin
            k_want = K_W'(1);
        end else if (int'(i_top_k) > MAX_TOP_K) begin
            k_want = K_W'(MAX_TOP_K);
        end else begin
            k_want = K_W'(i_top_k);
        end
        if (int'(k_want) > int'(r_count)) begin
            k_clamp = K_W'(r_count);
        end else begin
            k_clamp = k_want;
        end
    end

    assign full   = (int'(r_count) >= MAX_ENTRIES);
    assign s_next = DLEN_W'(r_sptr) + DLEN_W'(1);
    assign q_next = DLEN_W'(r_qptr) + DLEN_W'(1);
    assign s_done = i_last_element || (s_next >= eff_dims);
    assign q_done = i_last_element || (q_next >= eff_dims);

    // item decode
    always_comb begin
        n_count    = r_count;
        n_sptr     = r_sptr;
        n_qptr     = r_qptr;
        o_job_push = 1'b0;
        o_job      = '{kind: ST_MATCH, k: k_clamp, count: r_count, qlen: q_next,
                       dims: eff_dims};
        o_store_wr = '{en: 1'b0, addr: {r_count[IDX_W-1:0], r_sptr},
                       data: i_element_value};
        o_len_wr   = '{en: 1'b0, addr: r_count[IDX_W-1:0], data: s_next};
        o_qry_wr   = '{en: 1'b0, addr: r_qptr, data: i_element_value};
        if (i_item_valid) begin
            unique case (i_func)
                FUNC_CLEAR: begin
                    n_count = '0;
                    n_sptr  = '0;
                end
                FUNC_APPEND: begin
                    o_store_wr.en = !full;
                    o_len_wr.en   = !full;
                    if (s_done) begin
                        n_sptr = '0;
                        if (full) begin
                            o_job_push = 1'b1;
                            o_job.kind = ST_FULL;
                        end else begin
                            n_count = r_count + COUNT_W'(1);
                        end
                    end else begin
                        n_sptr = r_sptr + DIM_W'(1);
                    end
                end
                FUNC_QUERY: begin
                    o_qry_wr.en = 1'b1;
                    if (q_done) begin
                        n_qptr     = '0;
                        o_job_push = 1'b1;
                        if (r_count == '0) begin
                            o_job.kind = ST_EMPTY;
                        end
                    end else begin
                        n_qptr = r_qptr + DIM_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims_cfg <= CFG_W'(64);
            r_count    <= '0;
            r_sptr     <= '0;
            r_qptr     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_dims_cfg <= i_cfg_dims;
            end
            r_count <= n_count;
            r_sptr  <= n_sptr;
            r_qptr  <= n_qptr;
        end
    end

endmodule

/* hw/rtl/tkdp_fifo.sv */
// ---------------------------------------------------------------------------
// tkdp_fifo
// Short job queue between the front and the back.
// ---------------------------------------------------------------------------
module tkdp_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tkdp_pkg::t_job   i_job,
    input  logic             i_pop,
    output logic             o_valid,
    output tkdp_pkg::t_job   o_job
);
    import tkdp_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_job             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign do_push = i_push && (int'(r_cnt) < FIFO_DEPTH);
    assign do_pop  = i_pop && (r_cnt != '0);
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (int'(r_wp) == FIFO_DEPTH - 1) ? '0 : r_wp + PTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= (int'(r_rp) == FIFO_DEPTH - 1) ? '0 : r_rp + PTR_W'(1);
            end
            r_cnt <= r_cnt + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

endmodule

/* hw/rtl/tkdp_back.sv */
// ---------------------------------------------------------------------------
// tkdp_back
// Scan engine: dot products over the store, sorted best list, result drive.
// ---------------------------------------------------------------------------
module tkdp_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_job_valid,
    input  tkdp_pkg::t_job                    i_job,
    output logic                              o_job_pop,
    output logic [tkdp_pkg::STORE_AW-1:0]     o_store_raddr,
    input  logic [tkdp_pkg::ELEM_W-1:0]       i_store_rdata,
    output logic [tkdp_pkg::IDX_W-1:0]        o_len_raddr,
    input  logic [tkdp_pkg::DLEN_W-1:0]       i_len_rdata,
    output logic [tkdp_pkg::DIM_W-1:0]        o_qry_raddr,
    input  logic [tkdp_pkg::ELEM_W-1:0]       i_qry_rdata,
    output logic                              o_busy,
    output logic                              o_result_valid,
    output logic [tkdp_pkg::OUT_IDX_W-1:0]    o_entry_index,
    output logic [tkdp_pkg::SIM_W-1:0]        o_similarity,
    output logic [1:0]                        o_status,
    output logic                              o_last_result
);
    import tkdp_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_EMIT} t_state;

    localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-32){1'b0}}, 32'h7FFF_FFFF};
    localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-32){1'b1}}, 32'h8000_0000};

    t_state              r_state;
    t_job                r_job;
    logic [IDX_W-1:0]    r_e;
    logic [DIM_W-1:0]    r_d;
    logic [SLOT_W-1:0]   r_n;

    // pipeline: p1 = memory read, p2 = product, p3 = finished sum
    logic                r_p1_v, r_p1_first, r_p1_last;
    logic [DIM_W-1:0]    r_p1_d;
    logic [IDX_W-1:0]    r_p1_e;
    logic                r_p2_v, r_p2_first, r_p2_last;
    logic [IDX_W-1:0]    r_p2_e;
    logic signed [31:0]  r_prod;
    logic                r_p3_v;
    logic [IDX_W-1:0]    r_p3_e;
    logic signed [ACC_W-1:0] r_acc;

    t_best               r_best [MAX_TOP_K];
    t_best               n_best [MAX_TOP_K];
    logic [MAX_TOP_K-1:0] ins;
    logic signed [SIM_W-1:0] sim_sat;

    logic                r_o_valid, r_o_last;
    logic [OUT_IDX_W-1:0] r_o_idx;
    logic [SIM_W-1:0]    r_o_sim;
    t_status             r_o_status;

    logic                d_last;
    logic                e_last;
    logic                pipe_empty;
    logic                use_elem;
    logic                emit_last;

    assign d_last     = (DLEN_W'(r_d) + DLEN_W'(1)) == r_job.dims;
    assign e_last     = (COUNT_W'(r_e) + COUNT_W'(1)) == r_job.count;
    assign pipe_empty = !r_p1_v && !r_p2_v && !r_p3_v;
    assign use_elem   = (DLEN_W'(r_p1_d) < r_job.qlen) && (DLEN_W'(r_p1_d) < i_len_rdata);
    assign emit_last  = (K_W'(r_n) + K_W'(1)) == r_job.k;

    assign o_store_raddr = {r_e, r_d};
    assign o_len_raddr   = r_e;
    assign o_qry_raddr   = r_d;
    assign o_job_pop     = (r_state == S_IDLE) && i_job_valid;

    // saturate finished sum to Q2.30
    always_comb begin
        if (r_acc > SAT_HI) begin
            sim_sat = 32'sh7FFF_FFFF;
        end else if (r_acc < SAT_LO) begin
            sim_sat = 32'sh8000_0000;
        end else begin
            sim_sat = r_acc[SIM_W-1:0];
        end
    end

    // sorted insert: strict greater wins, so ties keep the earlier entry
    always_comb begin
        for (int i = 0; i < MAX_TOP_K; i++) begin
            ins[i] = !r_best[i].valid || (sim_sat > $signed(r_best[i].sim));
        end
        for (int i = 0; i < MAX_TOP_K; i++) begin
            if (!r_p3_v || !ins[i]) begin
                n_best[i] = r_best[i];
            end else if (i == 0) begin
                n_best[i] = '{valid: 1'b1, idx: r_p3_e, sim: sim_sat};
            end else if (!ins[(i > 0) ? i - 1 : 0]) begin
                n_best[i] = '{valid: 1'b1, idx: r_p3_e, sim: sim_sat};
            end else begin
                n_best[i] = r_best[(i > 0) ? i - 1 : 0];
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_p1_d     <= r_d;
        r_p1_e     <= r_e;
        r_p1_first <= (r_d == '0);
        r_p1_last  <= d_last;
        r_p2_first <= r_p1_first;
        r_p2_last  <= r_p1_last;
        r_p2_e     <= r_p1_e;
        r_prod     <= use_elem ? $signed(i_qry_rdata) * $signed(i_store_rdata) : 32'sd0;
        r_p3_e     <= r_p2_e;
        if (r_p2_v) begin
            r_acc <= (r_p2_first ? '0 : r_acc) + ACC_W'(r_prod);
        end
        if (o_job_pop) begin
            r_job <= i_job;
        end
    end

    // control, best list and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_e       <= '0;
            r_d       <= '0;
            r_n       <= '0;
            r_p1_v    <= 1'b0;
            r_p2_v    <= 1'b0;
            r_p3_v    <= 1'b0;
            r_o_valid <= 1'b0;
            r_o_last  <= 1'b0;
            r_o_idx   <= '0;
            r_o_sim   <= '0;
            r_o_status <= ST_MATCH;
            for (int i = 0; i < MAX_TOP_K; i++) begin
                r_best[i].valid <= 1'b0;
            end
        end else begin
            r_p1_v    <= (r_state == S_SCAN);
            r_p2_v    <= r_p1_v;
            r_p3_v    <= r_p2_v && r_p2_last;
            r_o_valid <= 1'b0;
            for (int i = 0; i < MAX_TOP_K; i++) begin
                r_best[i] <= n_best[i];
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        if (i_job.kind == ST_MATCH) begin
                            r_state <= S_SCAN;
                            r_e     <= '0;
                            r_d     <= '0;
                            for (int i = 0; i < MAX_TOP_K; i++) begin
                                r_best[i].valid <= 1'b0;
                            end
                        end else begin
                            r_o_valid  <= 1'b1;
                            r_o_last   <= 1'b1;
                            r_o_idx    <= '0;
                            r_o_sim    <= '0;
                            r_o_status <= i_job.kind;
                        end
                    end
                end
                S_SCAN: begin
                    if (d_last) begin
                        r_d <= '0;
                        if (e_last) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_e <= r_e + IDX_W'(1);
                        end
                    end else begin
                        r_d <= r_d + DIM_W'(1);
                    end
                end
                S_DRAIN: begin
                    if (pipe_empty) begin
                        r_state <= S_EMIT;
                        r_n     <= '0;
                    end
                end
                S_EMIT: begin
                    r_o_valid  <= 1'b1;
                    r_o_last   <= emit_last;
                    r_o_idx    <= OUT_IDX_W'(r_best[r_n].idx);
                    r_o_sim    <= r_best[r_n].sim;
                    r_o_status <= ST_MATCH;
                    if (emit_last) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_n <= r_n + SLOT_W'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy         = (r_state != S_IDLE) || r_o_valid;
    assign o_result_valid = r_o_valid;
    assign o_entry_index  = r_o_idx;
    assign o_similarity   = r_o_sim;
    assign o_status       = r_o_status;
    assign o_last_result  = r_o_last;

endmodule

/* hw/rtl/top_k_dot_product_search_top.sv */
// ---------------------------------------------------------------------------
// top_k_dot_product_search_top
// Brute-force top-k inner product search over a store of Q1.15 embeddings.
// ---------------------------------------------------------------------------
//  channel   handshake                        payload
//  item in   start, busy (accept: start&!busy) i_func, i_element_value,
//                                              i_last_element, i_top_k
//  result    o_result_valid (one-cycle strobe) o_entry_index, o_similarity,
//                                              o_status, o_last_result
//  config    i_cfg_valid, o_cfg_ready          i_cfg_dims_in_use
//
//  Clear items, and load items that find room, post no job; busy stays low
//  after them. A completing query scans entries * dims elements through the
//  single multiply-accumulate pipe fed by the store RAM read port, then drains
//  the pipe and shows its results back to back.
//  busy stays high until the last result has been shown.
//  Reset (i_rst_n low, synchronous) empties the store and the job queue;
//  no clearing pass is needed. The receiver cannot stall results.
// ---------------------------------------------------------------------------
module top_k_dot_product_search_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_func,
    input  logic signed [tkdp_pkg::ELEM_W-1:0]  i_element_value,
    input  logic                                i_last_element,
    input  logic [tkdp_pkg::TOPK_IN_W-1:0]      i_top_k,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tkdp_pkg::CFG_W-1:0]          i_cfg_dims_in_use,
    output logic                                o_result_valid,
    output logic [tkdp_pkg::OUT_IDX_W-1:0]      o_entry_index,
    output logic signed [tkdp_pkg::SIM_W-1:0]   o_similarity,
    output logic [1:0]                          o_status,
    output logic                                o_last_result
);
    import tkdp_pkg::*;

    logic                 item_acc;
    t_job                 push_job;
    logic                 push;
    t_job                 q_job;
    logic                 q_valid;
    logic                 pop;
    t_store_wr            store_wr;
    t_len_wr              len_wr;
    t_qry_wr              qry_wr;
    logic [STORE_AW-1:0]  store_raddr;
    logic [ELEM_W-1:0]    store_rdata;
    logic [IDX_W-1:0]     len_raddr;
    logic [DLEN_W-1:0]    len_rdata;
    logic [DIM_W-1:0]     qry_raddr;
    logic [ELEM_W-1:0]    qry_rdata;
    logic                 back_busy;
    logic [SIM_W-1:0]     sim;

    assign item_acc    = start && !busy;
    assign busy        = q_valid || back_busy;
    assign o_cfg_ready = 1'b1;
    assign o_similarity = $signed(sim);

    // front: item decode and memory loads
    tkdp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_valid    (item_acc),
        .i_func          (i_func),
        .i_element_value (i_element_value),
        .i_last_element  (i_last_element),
        .i_top_k         (i_top_k),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_dims      (i_cfg_dims_in_use),
        .o_job           (push_job),
        .o_job_push      (push),
        .o_store_wr      (store_wr),
        .o_len_wr        (len_wr),
        .o_qry_wr        (qry_wr)
    );

    // job queue
    tkdp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    // embedding store, one row per entry
    tkdp_ram #(.WIDTH(ELEM_W), .DEPTH(STORE_DEPTH)) u_store_ram (
        .i_clk   (i_clk),
        .i_we    (store_wr.en),
        .i_waddr (store_wr.addr),
        .i_wdata (store_wr.data),
        .i_raddr (store_raddr),
        .o_rdata (store_rdata)
    );

    // written length of each entry; elements beyond it read as zero
    tkdp_ram #(.WIDTH(DLEN_W), .DEPTH(MAX_ENTRIES)) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_wr.en),
        .i_waddr (len_wr.addr),
        .i_wdata (len_wr.data),
        .i_raddr (len_raddr),
        .o_rdata (len_rdata)
    );

    // query buffer
    tkdp_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_DIMS)) u_qry_ram (
        .i_clk   (i_clk),
        .i_we    (qry_wr.en),
        .i_waddr (qry_wr.addr),
        .i_wdata (qry_wr.data),
        .i_raddr (qry_raddr),
        .o_rdata (qry_rdata)
    );

    // back: scan and result drive
    tkdp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (q_valid),
        .i_job          (q_job),
        .o_job_pop      (pop),
        .o_store_raddr  (store_raddr),
        .i_store_rdata  (store_rdata),
        .o_len_raddr    (len_raddr),
        .i_len_rdata    (len_rdata),
        .o_qry_raddr    (qry_raddr),
        .i_qry_rdata    (qry_rdata),
        .o_busy         (back_busy),
        .o_result_valid (o_result_valid),
        .o_entry_index  (o_entry_index),
        .o_similarity   (sim),
        .o_status       (o_status),
        .o_last_result  (o_last_result)
    );

endmodule

/* hw/rtl/tkdp_checker.sv */
// ---------------------------------------------------------------------------
// tkdp_checker
// Port-level checks of the search block, bound to the top level.
// ---------------------------------------------------------------------------
`include "top_k_dot_product_search_top_assert.svh"

module tkdp_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [1:0]                          i_func,
    input  logic signed [tkdp_pkg::ELEM_W-1:0]  i_element_value,
    input  logic                                i_last_element,
    input  logic [tkdp_pkg::TOPK_IN_W-1:0]      i_top_k,
    input  logic                                i_cfg_valid,
    input  logic                                o_cfg_ready,
    input  logic [tkdp_pkg::CFG_W-1:0]          i_cfg_dims_in_use,
    input  logic                                o_result_valid,
    input  logic [tkdp_pkg::OUT_IDX_W-1:0]      o_entry_index,
    input  logic signed [tkdp_pkg::SIM_W-1:0]   o_similarity,
    input  logic [1:0]                          o_status,
    input  logic                                o_last_result
);
    import tkdp_pkg::*;

    // a result is only shown while the block reports busy
    `TKDP_ASSERT_NOW(a_result_in_busy, o_result_valid, busy)

    // status results stand alone and carry zero payload
    `TKDP_ASSERT_NOW(a_status_alone, o_result_valid && (o_status != ST_MATCH),
        o_last_result && (o_entry_index == '0) && (o_similarity == '0))

    // results of one scan come out back to back
    `TKDP_ASSERT_NEXT(a_burst, o_result_valid && !o_last_result,
        o_result_valid && (o_status == ST_MATCH))

    // a burst stays ordered best first
    `TKDP_ASSERT_NEXT(a_sorted, o_result_valid && !o_last_result,
        o_similarity <= $past(o_similarity))

endmodule

bind top_k_dot_product_search_top tkdp_checker u_tkdp_checker (.*);

/* test/tb_top_k_dot_product_search_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top_k_dot_product_search_top
// Self-checking bench for the top-k dot product search block: a queue-fed
// command driver with random idling, a golden search model and a result
// monitor; covers empty and full store, saturation, ties and k clamping.
// ----------------------------------------------------------------------------
module tb_top_k_dot_product_search_top;
    import tkdp_pkg::*;

    typedef struct {
        logic [1:0]        func;
        logic signed [15:0] elem;
        logic              last;
        logic [4:0]        topk;
    } t_cmd;

    typedef struct {
        logic [7:0]         idx;
        logic signed [31:0] sim;
        logic [1:0]         st;
        logic               last;
    } t_hit;

    localparam int FUNC_NOP  = 3;
    localparam int WDOG_MAX  = 100000;

    logic i_clk, i_rst_n, busy;
    logic start = 1'b0;
    logic [1:0] i_func = '0;
    logic signed [15:0] i_element_value = '0;
    logic i_last_element = 1'b0;
    logic [4:0] i_top_k = '0;
    logic i_cfg_valid, o_cfg_ready;
    logic [6:0] i_cfg_dims_in_use;
    logic o_result_valid;
    logic [7:0] o_entry_index;
    logic signed [31:0] o_similarity;
    logic [1:0] o_status;
    logic o_last_result;

    top_k_dot_product_search_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_element_value(i_element_value),
        .i_last_element(i_last_element), .i_top_k(i_top_k),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_dims_in_use(i_cfg_dims_in_use), .o_result_valid(o_result_valid),
        .o_entry_index(o_entry_index), .o_similarity(o_similarity),
        .o_status(o_status), .o_last_result(o_last_result)
    );

    // model state
    logic signed [15:0] emb_store [MAX_ENTRIES][MAX_DIMS];
    logic signed [15:0] qry_buf [MAX_DIMS];
    int unsigned n_entries, st_ptr, q_ptr;
    logic [6:0] dims_reg;

    t_cmd pending_cmds[$];
    t_hit expected_hits[$];
    int   n_fail, n_sent, wdog;
    bit   cfg_done;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int eff_dims();
        if (dims_reg < 1) return 1;
        if (dims_reg > MAX_DIMS) return MAX_DIMS;
        return dims_reg;
    endfunction

    function automatic logic signed [31:0] dot_sat(int unsigned e, int dims);
        longint acc;
        acc = 0;
        for (int d = 0; d < dims; d++) acc += longint'(qry_buf[d]) * emb_store[e][d];
        if (acc > 64'sd2147483647) return 32'sh7fffffff;
        if (acc < -64'sd2147483648) return 32'sh80000000;
        return acc[31:0];
    endfunction

    // golden search model: one accepted item -> zero or more expected hits
    task automatic search_model(t_cmd c);
        int dims, k, p;
        bit done, full;
        bit bv [MAX_TOP_K];
        int bi [MAX_TOP_K];
        logic signed [31:0] bs [MAX_TOP_K];
        logic signed [31:0] s;
        t_hit h;
        dims = eff_dims();
        case (c.func)
            FUNC_CLEAR: begin
                n_entries = 0;
                st_ptr = 0;
            end
            FUNC_APPEND: begin
                p = st_ptr;
                full = (n_entries >= MAX_ENTRIES);
                if (!full && p < MAX_DIMS) begin
                    if (p == 0) for (int d = 0; d < MAX_DIMS; d++) emb_store[n_entries][d] = '0;
                    emb_store[n_entries][p] = c.elem;
                end
                done = c.last || (p + 1 >= dims);
                if (!done) st_ptr = p + 1;
                else begin
                    st_ptr = 0;
                    if (full) begin
                        h = '{8'd0, 32'sd0, ST_FULL, 1'b1};
                        expected_hits.insert(expected_hits.size(), h);
                    end else n_entries++;
                end
            end
            FUNC_QUERY: begin
                p = q_ptr;
                if (p < MAX_DIMS) begin
                    if (p == 0) for (int d = 0; d < MAX_DIMS; d++) qry_buf[d] = '0;
                    qry_buf[p] = c.elem;
                end
                done = c.last || (p + 1 >= dims);
                if (!done) q_ptr = p + 1;
                else begin
                    q_ptr = 0;
                    if (n_entries == 0) begin
                        h = '{8'd0, 32'sd0, ST_EMPTY, 1'b1};
                        expected_hits.insert(expected_hits.size(), h);
                    end else begin
                        k = c.topk;
                        if (k < 1) k = 1;
                        if (k > MAX_TOP_K) k = MAX_TOP_K;
                        if (k > n_entries) k = n_entries;
                        for (int j = 0; j < MAX_TOP_K; j++) bv[j] = 1'b0;
                        // sorted insert, strict compare keeps lower index on ties
                        for (int e = 0; e < n_entries; e++) begin
                            s = dot_sat(e, dims);
                            p = 0;
                            while (p < k && bv[p] && s <= bs[p]) p++;
                            if (p < k) begin
                                for (int j = k - 1; j > p; j--) begin
                                    bv[j] = bv[j-1]; bi[j] = bi[j-1]; bs[j] = bs[j-1];
                                end
                                bv[p] = 1'b1; bi[p] = e; bs[p] = s;
                            end
                        end
                        for (int n = 0; n < k; n++) begin
                            h = '{bi[n][7:0], bs[n], ST_MATCH, (n + 1 == k)};
                            expected_hits.insert(expected_hits.size(), h);
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    // command driver
    always @(posedge i_clk) begin
        bit go;
        go = 1'b0;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                search_model(pending_cmds.pop_front());
                n_sent++;
            end
            if (pending_cmds.size() != 0) begin
                if (start && busy) go = 1'b1;
                else if ((n_sent > 150 && n_sent < 260) || $urandom_range(99) >= 13) go = 1'b1;
            end
            start <= go;
            if (go) begin
                i_func          <= pending_cmds[0].func;
                i_element_value <= pending_cmds[0].elem;
                i_last_element  <= pending_cmds[0].last;
                i_top_k         <= pending_cmds[0].topk;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_hit e;
        if (i_rst_n && o_result_valid) begin
            if (expected_hits.size() == 0) begin
                n_fail++;
                if (n_fail <= 10) $display("unexpected result idx=%0d sim=%0d st=%0d",
                                           o_entry_index, o_similarity, o_status);
            end else begin
                e = expected_hits.pop_front();
                if (o_entry_index !== e.idx || o_similarity !== e.sim ||
                    o_status !== e.st || o_last_result !== e.last) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("mismatch exp idx=%0d sim=%0d st=%0d last=%0d got %0d %0d %0d %0d",
                                 e.idx, e.sim, e.st, e.last, o_entry_index, o_similarity,
                                 o_status, o_last_result);
                end
            end
        end
    end

    // watchdog on cycles without any accepted traffic
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid || (i_cfg_valid && o_cfg_ready))
            wdog <= 0;
        else begin
            wdog <= wdog + 1;
            if (wdog >= WDOG_MAX) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic logic signed [15:0] rnd_elem();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_cmd(int f, logic signed [15:0] v, bit l, int k);
        t_cmd c;
        c.func = 2'(f); c.elem = v; c.last = l; c.topk = 5'(k);
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    // wait for all items and results, let the block drain, then stay idle
    task automatic drain_all();
        while (pending_cmds.size() != 0 || start || expected_hits.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_dims(logic [6:0] v);
        drain_all();
        @(posedge i_clk);
        i_cfg_valid       <= 1'b1;
        i_cfg_dims_in_use <= v;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        dims_reg = v;
    endtask

    // vectors of random content; mostly short via last_element, some full length
    task automatic random_phase(int nvec, int nqry);
        int dims, len;
        dims = eff_dims();
        push_cmd(FUNC_CLEAR, rnd_elem(), 1'($urandom_range(1)), $urandom_range(31));
        for (int v = 0; v < nvec + nqry; v++) begin
            len = ($urandom_range(9) == 0) ? dims : $urandom_range(1, (dims < 5) ? dims : 5);
            for (int i = 0; i < len; i++)
                push_cmd((v < nvec) ? FUNC_APPEND : FUNC_QUERY, rnd_elem(),
                         (i == len - 1) && (len < dims || $urandom_range(1)),
                         $urandom_range(31));
            if ($urandom_range(9) == 0)
                push_cmd(FUNC_NOP, rnd_elem(), 1'($urandom_range(1)), $urandom_range(31));
            if (v >= nvec && $urandom_range(3) == 0) begin
                push_cmd(FUNC_APPEND, rnd_elem(), 1'b1, $urandom_range(31));
            end
        end
    endtask

    initial begin
        dims_reg = 7'd64;
        i_rst_n = 1'b0; i_cfg_valid = 1'b0;
        i_cfg_dims_in_use = 7'd64;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty store, saturation both ways, ties, k clamping, unused func
        push_cmd(FUNC_QUERY, 16'sh7fff, 1'b1, 5'd3);
        for (int i = 0; i < 3; i++) push_cmd(FUNC_APPEND, 16'sh8000, i == 2, 0);
        for (int i = 0; i < 3; i++) push_cmd(FUNC_APPEND, 16'sh7fff, i == 2, 0);
        push_cmd(FUNC_APPEND, 16'sh0000, 1'b1, 0);
        for (int i = 0; i < 3; i++) push_cmd(FUNC_APPEND, 16'sh8000, i == 2, 0);
        for (int i = 0; i < 3; i++) push_cmd(FUNC_QUERY, 16'sh8000, i == 2, 0);
        for (int i = 0; i < 3; i++) push_cmd(FUNC_QUERY, 16'sh7fff, i == 2, 31);
        push_cmd(FUNC_NOP, 16'sh7fff, 1'b1, 31);
        push_cmd(FUNC_CLEAR, 16'sh0000, 1'b0, 0);
        push_cmd(FUNC_QUERY, 16'sh0001, 1'b1, 16);

        // full store at one element per vector: drops flagged, full index range
        write_dims(7'd1);
        push_cmd(FUNC_CLEAR, 16'sh0000, 1'b0, 0);
        for (int i = 0; i < MAX_ENTRIES + 2; i++)
            push_cmd(FUNC_APPEND, rnd_elem(), 1'($urandom_range(1)), $urandom_range(31));
        push_cmd(FUNC_QUERY, rnd_elem(), 1'b0, 16);
        push_cmd(FUNC_QUERY, rnd_elem(), 1'b1, 17);

        write_dims(7'd0);
        random_phase(6, 4);
        write_dims(7'd127);
        random_phase(4, 2);
        write_dims(7'd3);
        random_phase(10, 8);
        write_dims(7'd64);
        random_phase(4, 2);
        write_dims(7'd17);
        random_phase(6, 4);

        drain_all();
        repeat (20) @(posedge i_clk);
        if (n_fail == 0 && expected_hits.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
